// ===== sv/dit_pkg.sv =====
// Package for the two-timer interval timer peripheral: item types, request codes,
// register map codes and control word bit positions.
// No dependencies.
package dit_pkg;

   localparam int TIMER_COUNT = 2;

   localparam logic [1:0] REQ_READ  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_TICK  = 2'd2;

   localparam logic [3:0] ADDR_IRQ_ENABLE = 4'd0;
   localparam logic [3:0] ADDR_IRQ_STATUS = 4'd1;

   localparam logic [1:0] REG_CONTROL  = 2'd0;
   localparam logic [1:0] REG_INTERVAL = 2'd1;
   localparam logic [1:0] REG_CURRENT  = 2'd2;

   localparam int CTL_ENABLE    = 0;
   localparam int CTL_RELOAD    = 1;
   localparam int CTL_SRC24     = 2;
   localparam int CTL_PRE_LSB   = 4;
   localparam int CTL_PRE_MSB   = 6;
   localparam int CTL_SINGLE    = 7;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [3:0]  address;
      logic [31:0] write_data;
      logic        slow_edge;
   } req_item_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [1:0]  irq_lines;
   } rsp_item_type;

endpackage

// ===== sv/dual_interval_timer_peripheral_unit.sv =====
// Top level of the two-timer interval timer peripheral: input register, register
// map, timer update logic and result register.
// Depends on dit_pkg.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_ready   req_data (read, write or tick item)
//   rsp       out        rsp_valid/rsp_ready   rsp_data (read data, interrupt lines)
//
// Every item goes from the input register through the register map and timer logic
// into the result register. One item is accepted per cycle; the input register
// only waits when the result register holds an item that has not been taken.
// Synchronous reset clears all registers of the map and both pipeline valids.
module dual_interval_timer_peripheral_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  dit_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output dit_pkg::rsp_item_type rsp_data
);

   localparam int TC = dit_pkg::TIMER_COUNT;

   localparam logic [3:0] ADDR_IRQ_ENABLE_C = dit_pkg::ADDR_IRQ_ENABLE;
   localparam logic [3:0] ADDR_IRQ_STATUS_C = dit_pkg::ADDR_IRQ_STATUS;

   logic                  in_valid_ff;
   logic                  in_valid_in;
   dit_pkg::req_item_type in_item_ff;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   dit_pkg::rsp_item_type out_item_ff;
   dit_pkg::rsp_item_type out_item_in;
   logic                  advance;

   logic [TC-1:0] enable_ff;
   logic [TC-1:0] enable_in;
   logic [TC-1:0] status_ff;
   logic [TC-1:0] status_in;
   logic [7:0]    control_ff  [TC];
   logic [7:0]    control_in  [TC];
   logic [31:0]   interval_ff [TC];
   logic [31:0]   interval_in [TC];
   logic [31:0]   current_ff  [TC];
   logic [31:0]   current_in  [TC];
   logic [6:0]    prescale_ff [TC];
   logic [6:0]    prescale_in [TC];

   logic [31:0]   read_value;
   logic [TC-1:0] reload_seen;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_comb begin
      read_value = '0;
      if (in_item_ff.address == ADDR_IRQ_ENABLE_C) begin
         read_value = 32'(enable_ff);
      end else if (in_item_ff.address == ADDR_IRQ_STATUS_C) begin
         read_value = 32'(status_ff);
      end
      for (int t = 0; t < TC; t++) begin
         if ({1'b0, in_item_ff.address[3:2]} == 3'(t + 1)) begin
            case (in_item_ff.address[1:0])
               dit_pkg::REG_CONTROL:  read_value = 32'(control_ff[t]);
               dit_pkg::REG_INTERVAL: read_value = interval_ff[t];
               dit_pkg::REG_CURRENT:  read_value = current_ff[t];
               default:               read_value = '0;
            endcase
         end
      end
   end

   always_comb begin
      logic [7:0] pre_next;
      logic [7:0] pre_limit;
      logic       sel;
      enable_in = enable_ff;
      status_in = status_ff;
      for (int t = 0; t < TC; t++) begin
         control_in[t]  = control_ff[t];
         interval_in[t] = interval_ff[t];
         current_in[t]  = current_ff[t];
         prescale_in[t] = prescale_ff[t];
      end
      pre_next  = '0;
      pre_limit = '0;
      sel       = 1'b0;
      if (advance) begin
         unique case (in_item_ff.req_type)
            dit_pkg::REQ_WRITE: begin
               if (in_item_ff.address == ADDR_IRQ_ENABLE_C) begin
                  enable_in = in_item_ff.write_data[TC-1:0];
               end else if (in_item_ff.address == ADDR_IRQ_STATUS_C) begin
                  status_in = status_ff & ~in_item_ff.write_data[TC-1:0];
               end
               for (int t = 0; t < TC; t++) begin
                  sel = ({1'b0, in_item_ff.address[3:2]} == 3'(t + 1));
                  if (sel) begin
                     case (in_item_ff.address[1:0])
                        dit_pkg::REG_CONTROL: begin
                           control_in[t] = in_item_ff.write_data[7:0];
                           control_in[t][dit_pkg::CTL_RELOAD] = 1'b0;
                           if (in_item_ff.write_data[dit_pkg::CTL_RELOAD]) begin
                              current_in[t]  = interval_ff[t];
                              prescale_in[t] = '0;
                           end
                        end
                        dit_pkg::REG_INTERVAL: interval_in[t] = in_item_ff.write_data;
                        dit_pkg::REG_CURRENT:  current_in[t]  = in_item_ff.write_data;
                        default: ;
                     endcase
                  end
               end
            end
            dit_pkg::REQ_TICK: begin
               for (int t = 0; t < TC; t++) begin
                  if (control_ff[t][dit_pkg::CTL_ENABLE] &&
                      (control_ff[t][dit_pkg::CTL_SRC24] || in_item_ff.slow_edge)) begin
                     pre_next  = {1'b0, prescale_ff[t]} + 8'd1;
                     pre_limit = 8'd1 <<
                        control_ff[t][dit_pkg::CTL_PRE_MSB:dit_pkg::CTL_PRE_LSB];
                     if (pre_next >= pre_limit) begin
                        prescale_in[t] = '0;
                        if (current_ff[t] <= 32'd1) begin
                           status_in[t] = 1'b1;
                           if (control_ff[t][dit_pkg::CTL_SINGLE]) begin
                              current_in[t] = '0;
                              control_in[t][dit_pkg::CTL_ENABLE] = 1'b0;
                           end else begin
                              current_in[t] = interval_ff[t];
                           end
                        end else begin
                           current_in[t] = current_ff[t] - 32'd1;
                        end
                     end else begin
                        prescale_in[t] = pre_next[6:0];
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      out_item_in.read_data = (in_item_ff.req_type == dit_pkg::REQ_READ) ? read_value : '0;
      out_item_in.irq_lines = 2'(status_in & enable_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         enable_ff    <= '0;
         status_ff    <= '0;
         for (int t = 0; t < TC; t++) begin
            control_ff[t]  <= '0;
            interval_ff[t] <= '0;
            current_ff[t]  <= '0;
            prescale_ff[t] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         enable_ff    <= enable_in;
         status_ff    <= status_in;
         for (int t = 0; t < TC; t++) begin
            control_ff[t]  <= control_in[t];
            interval_ff[t] <= interval_in[t];
            current_ff[t]  <= current_in[t];
            prescale_ff[t] <= prescale_in[t];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_item_ff <= req_data;
      end
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

   always_comb begin
      for (int t = 0; t < TC; t++) begin
         reload_seen[t] = control_ff[t][dit_pkg::CTL_RELOAD];
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) reload_seen == '0)
      else $error("A stored control word holds the reload bit.");

   assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_data.irq_lines == 2'(status_ff & enable_ff)))
      else $error("Interrupt lines of the result do not match the registers.");

   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("The held input item was lost or overwritten.");

   assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(status_ff) && $stable(enable_ff)))
      else $error("Interrupt registers changed without an item.");
`endif

endmodule
